// File: hdl/sapf_pkg.sv
package sapf_pkg;

  // Width of the bytes fields when the top level is not overridden.
  localparam int unsigned BYTES_WIDTH_DEF = 48;

  // Cooldown register and countdown timer.
  localparam int unsigned COOLDOWN_W = 20;
  localparam int unsigned COUNT_W    = 22;
  localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 20'd600;
  localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  // Policy modes.
  localparam logic [1:0] MODE_DIET    = 2'd0;
  localparam logic [1:0] MODE_HUNGRY  = 2'd1;
  localparam logic [1:0] MODE_STEADY  = 2'd2;
  localparam logic [1:0] MODE_OVERFED = 2'd3;

  // Actions reported with each result.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Request kinds.
  localparam logic REQ_EVALUATE = 1'b0;
  localparam logic REQ_DIET     = 1'b1;

  // Control bits of one item handed to the policy unit.
  typedef struct packed {
    logic req_type;
    logic alloc_succeeds;
  } item_ctrl_t;

  // Control part of one result from the policy unit.
  typedef struct packed {
    logic [1:0] action;
    logic [1:0] mode;
  } result_ctrl_t;

endpackage

// File: hdl/sapf_policy.sv
module sapf_policy #(
  parameter int unsigned BYTES_WIDTH = sapf_pkg::BYTES_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sapf_pkg::COOLDOWN_W-1:0]     cfg_data_i,
  input  logic                                step_i,
  input  sapf_pkg::item_ctrl_t                ctrl_i,
  input  logic signed [BYTES_WIDTH-1:0]       req_bytes_i,
  output sapf_pkg::result_ctrl_t              res_o,
  output logic [BYTES_WIDTH-1:0]              res_bytes_o
);

  localparam int unsigned CW = sapf_pkg::COUNT_W;

  logic [sapf_pkg::COOLDOWN_W-1:0] cooldown_q;
  logic [1:0]                      mode_q, mode_d;
  logic signed [CW-1:0]            cnt_q, cnt_d;
  logic                            pend_q, pend_d;

  logic                 neg, pos, timeout;
  logic [BYTES_WIDTH-1:0] mag_neg;
  logic signed [CW-1:0] cnt_dec, reload;

  // Decode of the signed requirement.
  assign neg     = req_bytes_i[BYTES_WIDTH-1];
  assign pos     = !neg && (|req_bytes_i);
  assign mag_neg = BYTES_WIDTH'(~req_bytes_i) + BYTES_WIDTH'(1);

  // Timer tick saturates at the most negative count.
  assign reload  = {{(CW-sapf_pkg::COOLDOWN_W){1'b0}}, cooldown_q};
  assign cnt_dec = (cnt_q != sapf_pkg::COUNT_MIN) ? cnt_q - CW'(1) : cnt_q;
  assign timeout = cnt_dec[CW-1] || (cnt_dec == '0);

  // Next state and result for the item at the policy input.
  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    res_o.action = sapf_pkg::ACT_NONE;
    res_bytes_o = '0;
    if (ctrl_i.req_type == sapf_pkg::REQ_DIET) begin
      pend_d = 1'b1;
    end else if (pend_q) begin
      pend_d = 1'b0;
      mode_d = sapf_pkg::MODE_DIET;
      cnt_d  = reload;
    end else begin
      cnt_d = cnt_dec;
      priority if (pos && mode_q != sapf_pkg::MODE_DIET) begin
        if (ctrl_i.alloc_succeeds) begin
          res_o.action = sapf_pkg::ACT_ALLOC;
          res_bytes_o  = req_bytes_i;
          mode_d       = sapf_pkg::MODE_HUNGRY;
          cnt_d        = reload;
        end
      end else if (timeout) begin
        if (mode_q == sapf_pkg::MODE_OVERFED) begin
          res_o.action = sapf_pkg::ACT_FREE;
          res_bytes_o  = neg ? mag_neg : '0;
        end
        mode_d = sapf_pkg::MODE_STEADY;
        cnt_d  = reload;
      end else if (mode_q == sapf_pkg::MODE_DIET) begin
        if (neg) begin
          res_o.action = sapf_pkg::ACT_FREE;
          res_bytes_o  = mag_neg;
        end
      end else if (mode_q == sapf_pkg::MODE_STEADY) begin
        if (neg) begin
          mode_d = sapf_pkg::MODE_OVERFED;
          cnt_d  = reload;
        end
      end else if (mode_q == sapf_pkg::MODE_OVERFED) begin
        if (!neg) begin
          mode_d = sapf_pkg::MODE_STEADY;
          cnt_d  = reload;
        end
      end else begin
        // Hungry without a shortage only lets the timer tick.
        mode_d = mode_q;
      end
    end
    res_o.mode = mode_d;
  end

  // Policy state; a cooldown write also reloads the timer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q <= sapf_pkg::COOLDOWN_RESET;
      mode_q     <= sapf_pkg::MODE_HUNGRY;
      cnt_q      <= '0;
      pend_q     <= 1'b0;
    end else if (cfg_we_i) begin
      cooldown_q <= cfg_data_i;
      cnt_q      <= {{(CW-sapf_pkg::COOLDOWN_W){1'b0}}, cfg_data_i};
    end else if (step_i) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

// File: hdl/swap_allocation_policy_fsm.sv
// Channel    Direction  Handshake                    Contents
// s_axis     in         s_axis_tvalid/s_axis_tready  request item
// m_axis     out        m_axis_tvalid/m_axis_tready  action, bytes and mode
// cfg        in         cfg_valid_i/cfg_ready_o      cooldown_ticks
//
// An item passes through the input register and then the result register.
// One item per cycle is sustained while the result register is not stalled.
// The policy state updates when an item passes from the input to the result register.
// A stalled result holds the input register; a new item enters as soon as it frees.
// A cooldown write waits while an item sits in the input register.
// Reset puts the policy in hungry with the timer at zero and cooldown at 600.
module swap_allocation_policy_fsm #(
  parameter int unsigned BYTES_WIDTH = sapf_pkg::BYTES_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // Bits from 0: required_bytes, alloc_succeeds, zero fill.
  input  logic [((BYTES_WIDTH+1+7)/8)*8-1:0] s_axis_tdata,
  // Bit 0: req_type.
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // Bits from 0: action_bytes, mode, zero fill.
  output logic [((BYTES_WIDTH+2+7)/8)*8-1:0] m_axis_tdata,
  // Bits from 0: action.
  output logic [1:0]               m_axis_tuser,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [sapf_pkg::COOLDOWN_W-1:0] cfg_data_i
);

  logic                          in_valid_q;
  sapf_pkg::item_ctrl_t          in_ctrl_q;
  logic signed [BYTES_WIDTH-1:0] in_bytes_q;
  logic                          out_valid_q;
  sapf_pkg::result_ctrl_t        out_ctrl_q, res_ctrl;
  logic [BYTES_WIDTH-1:0]        out_bytes_q, res_bytes;
  logic                          advance;

  // An item moves on when the result register is free or being emptied.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  // A cooldown write never meets a policy step in the same cycle.
  assign cfg_ready_o   = !in_valid_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ctrl_q.req_type       <= s_axis_tuser;
      in_ctrl_q.alloc_succeeds <= s_axis_tdata[BYTES_WIDTH];
      in_bytes_q               <= s_axis_tdata[BYTES_WIDTH-1:0];
    end
  end

  sapf_policy #(
    .BYTES_WIDTH(BYTES_WIDTH)
  ) u_policy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .step_i      (advance),
    .ctrl_i      (in_ctrl_q),
    .req_bytes_i (in_bytes_q),
    .res_o       (res_ctrl),
    .res_bytes_o (res_bytes)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_ctrl_q  <= res_ctrl;
      out_bytes_q <= res_bytes;
    end
  end

  // Output packing.
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[BYTES_WIDTH-1:0]           = out_bytes_q;
    m_axis_tdata[BYTES_WIDTH+1:BYTES_WIDTH] = out_ctrl_q.mode;
  end
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ctrl_q.action;

`ifndef NO_ASSERTIONS
  // A result with no action carries no bytes.
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sapf_pkg::ACT_NONE)
      |-> (m_axis_tdata[BYTES_WIDTH-1:0] == '0))
    else $error("action none with nonzero bytes");

  // A granted allocation always lands in hungry.
  a_alloc_hungry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sapf_pkg::ACT_ALLOC)
      |-> (out_ctrl_q.mode == sapf_pkg::MODE_HUNGRY))
    else $error("allocate outside hungry");

  // Frees only happen while dieting or when overfed times out to steady.
  a_free_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == sapf_pkg::ACT_FREE)
      |-> (out_ctrl_q.mode == sapf_pkg::MODE_DIET ||
           out_ctrl_q.mode == sapf_pkg::MODE_STEADY))
    else $error("free in unexpected mode");

  // An item held in the input register is not dropped while blocked.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item lost while stalled");
`endif

endmodule

// File: dv/policy_checker.sv
module policy_checker #(
  parameter int unsigned BYTES_WIDTH = sapf_pkg::BYTES_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  input  logic                                      s_axis_tready,
  // Bits from 0: required_bytes, alloc_succeeds, zero fill.
  input  logic [((BYTES_WIDTH+1+7)/8)*8-1:0]        s_axis_tdata,
  // Bit 0: req_type.
  input  logic                                      s_axis_tuser,
  input  logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // Bits from 0: action_bytes, mode, zero fill.
  input  logic [((BYTES_WIDTH+2+7)/8)*8-1:0]        m_axis_tdata,
  // Bits from 0: action.
  input  logic [1:0]                                m_axis_tuser,
  input  logic                                      cfg_valid_i,
  input  logic                                      cfg_ready_o,
  input  logic [sapf_pkg::COOLDOWN_W-1:0]           cfg_data_i,
  output int                                        mismatches_o,
  output int                                        outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COOLDOWN_W = sapf_pkg::COOLDOWN_W;
  localparam int unsigned COUNT_W    = sapf_pkg::COUNT_W;

  // One predicted policy decision.
  typedef struct packed {
    logic [1:0]             action;
    logic [BYTES_WIDTH-1:0] nbytes;
    logic [1:0]             mode;
  } policy_decision_t;

  // Shadow copy of the policy state and the cooldown register.
  logic [COOLDOWN_W-1:0]     cooldown_q;
  logic [1:0]                mode_q;
  logic signed [COUNT_W-1:0] countdown_q;
  logic                      diet_pending_q;

  policy_decision_t decisions_q[$];
  policy_decision_t oldest;
  int               mismatches = 0;

  assign mismatches_o = mismatches;

  // Switch the mode and restart the cooldown timer.
  function automatic void switch_mode(input logic [1:0] next_mode);
    mode_q      = next_mode;
    countdown_q = {{(COUNT_W-COOLDOWN_W){1'b0}}, cooldown_q};
  endfunction

  // Advance the shadow state by one item and return the decision it yields.
  function automatic policy_decision_t decide_policy(input logic                   req_type,
                                                     input logic [BYTES_WIDTH-1:0] req,
                                                     input logic                   succeeds);
    policy_decision_t d;
    logic             neg;
    logic             pos;
    neg      = req[BYTES_WIDTH-1];
    pos      = !neg && (req != '0);
    d.action = sapf_pkg::ACT_NONE;
    d.nbytes = '0;
    if (req_type == sapf_pkg::REQ_DIET) begin
      diet_pending_q = 1'b1;
    end else if (diet_pending_q) begin
      // A pending diet request wins over the requirement and skips the tick.
      diet_pending_q = 1'b0;
      switch_mode(sapf_pkg::MODE_DIET);
    end else begin
      // The timer saturates at its most negative value.
      if (countdown_q != sapf_pkg::COUNT_MIN) begin
        countdown_q = countdown_q - 1;
      end
      if (pos && mode_q != sapf_pkg::MODE_DIET) begin
        if (succeeds) begin
          d.action = sapf_pkg::ACT_ALLOC;
          d.nbytes = req;
          switch_mode(sapf_pkg::MODE_HUNGRY);
        end
      end else if (countdown_q <= 0) begin
        if (mode_q == sapf_pkg::MODE_OVERFED) begin
          d.action = sapf_pkg::ACT_FREE;
          d.nbytes = neg ? ('0 - req) : '0;
        end
        switch_mode(sapf_pkg::MODE_STEADY);
      end else if (mode_q == sapf_pkg::MODE_DIET) begin
        if (neg) begin
          d.action = sapf_pkg::ACT_FREE;
          d.nbytes = '0 - req;
        end
      end else if (mode_q == sapf_pkg::MODE_STEADY) begin
        if (neg) begin
          switch_mode(sapf_pkg::MODE_OVERFED);
        end
      end else if (mode_q == sapf_pkg::MODE_OVERFED) begin
        if (!neg) begin
          switch_mode(sapf_pkg::MODE_STEADY);
        end
      end
    end
    d.mode = mode_q;
    return d;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Track configuration writes and input items, and compare every result item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cooldown_q     = sapf_pkg::COOLDOWN_RESET;
      mode_q         = sapf_pkg::MODE_HUNGRY;
      countdown_q    = '0;
      diet_pending_q = 1'b0;
      decisions_q.delete();
      outstanding_o <= 0;
    end else begin
      // Results are checked before new items are queued, since a result can
      // never belong to an item accepted at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (decisions_q.size() == 0) begin
          $error("result item arrived with no decision pending");
          mismatches++;
        end else begin
          oldest = decisions_q.pop_front();
          check_field("action", oldest.action, m_axis_tuser);
          check_field("action_bytes", oldest.nbytes, m_axis_tdata[BYTES_WIDTH-1:0]);
          check_field("mode", oldest.mode, m_axis_tdata[BYTES_WIDTH+1:BYTES_WIDTH]);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cooldown_q  = cfg_data_i;
        countdown_q = {{(COUNT_W-COOLDOWN_W){1'b0}}, cfg_data_i};
      end
      if (s_axis_tvalid && s_axis_tready) begin
        decisions_q.push_back(decide_policy(s_axis_tuser, s_axis_tdata[BYTES_WIDTH-1:0],
                                            s_axis_tdata[BYTES_WIDTH]));
      end
      outstanding_o <= decisions_q.size();
    end
  end

endmodule

// File: dv/tb_swap_allocation_policy_fsm.sv
module tb_swap_allocation_policy_fsm;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BW         = sapf_pkg::BYTES_WIDTH_DEF;
  localparam int unsigned COOLDOWN_W = sapf_pkg::COOLDOWN_W;
  localparam int unsigned IN_W       = ((BW+1+7)/8)*8;
  localparam int unsigned OUT_W      = ((BW+2+7)/8)*8;

  localparam logic [BW-1:0] MAX_POS = {1'b0, {(BW-1){1'b1}}};
  localparam logic [BW-1:0] MIN_NEG = {1'b1, {(BW-1){1'b0}}};

  // A run of failed allocations that keeps the timer ticking below zero.
  localparam int unsigned FAIL_ITEMS = 40;

  // Sign steering of random episodes.
  localparam int BIAS_MIXED    = 0;
  localparam int BIAS_SURPLUS  = 1;
  localparam int BIAS_SHORTAGE = 2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [COOLDOWN_W-1:0] cfg_data_i;

  int mismatch_total;
  int pending_results;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;

  swap_allocation_policy_fsm #(.BYTES_WIDTH(BW)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  policy_checker #(.BYTES_WIDTH(BW)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatch_total),
    .outstanding_o (pending_results)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #150ms;
    $display("tb: failure");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(8, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [BW-1:0] negated(input longint unsigned magnitude);
    return '0 - BW'(magnitude);
  endfunction

  function automatic logic [BW-1:0] random_bytes(input int bias);
    logic [BW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = MAX_POS;
      2:       v = MIN_NEG;
      3:       v = '1;
      4, 5:    v = BW'($urandom_range(1, 1000));
      default: v = BW'({$urandom(), $urandom()});
    endcase
    // Steer most items of a surplus or shortage episode to the matching sign.
    if ($urandom_range(0, 3) != 0) begin
      if (bias == BIAS_SURPLUS && !v[BW-1]) begin
        v = (v == '0) ? '1 : '0 - v;
      end else if (bias == BIAS_SHORTAGE && (v[BW-1] || v == '0)) begin
        v = (v == '0 || v == MIN_NEG) ? MAX_POS : '0 - v;
      end
    end
    return v;
  endfunction

  // Receiver: ready with random stalls at the current stall rate.
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) begin
          stall_left = gap_len();
        end
      end
    end
  end

  // Present one item, maybe after a gap, and hold it until it is taken.
  task automatic send_item(input logic kind, input logic [BW-1:0] req_bytes,
                           input logic succeeds);
    logic [IN_W-1:0] word;
    int              gap;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      gap = gap_len();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word           = '0;
    word[BW-1:0]   = req_bytes;
    word[BW]       = succeeds;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending and wait until every result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cooldown(input logic [COOLDOWN_W-1:0] ticks);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ticks;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random episodes: an optional diet request, then mostly evaluations of one flavor.
  task automatic run_random(input int count);
    int left;
    int bias;
    left = 0;
    bias = BIAS_MIXED;
    repeat (count) begin
      if (left == 0) begin
        left = $urandom_range(4, 16);
        bias = $urandom_range(0, 2);
        if ($urandom_range(0, 99) < 30) begin
          send_item(sapf_pkg::REQ_DIET, random_bytes(BIAS_MIXED),
                    1'($urandom_range(0, 1)));
        end
      end
      left--;
      if ($urandom_range(0, 99) < 4) begin
        send_item(sapf_pkg::REQ_DIET, random_bytes(BIAS_MIXED),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(sapf_pkg::REQ_EVALUATE, random_bytes(bias), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    logic [COOLDOWN_W-1:0] ticks;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = sapf_pkg::REQ_EVALUATE;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: timeout from reset, steady and overfed, extreme shortages.
    send_item(sapf_pkg::REQ_EVALUATE, '0, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, negated(5), 1'b1);
    send_item(sapf_pkg::REQ_EVALUATE, '0, 1'b1);
    send_item(sapf_pkg::REQ_EVALUATE, MAX_POS, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, MAX_POS, 1'b1);
    // Diet requests; the served one ignores its requirement.
    send_item(sapf_pkg::REQ_DIET, '1, 1'b1);
    send_item(sapf_pkg::REQ_DIET, MIN_NEG, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, BW'(100), 1'b1);
    // Freeing in diet, including the most negative requirement.
    send_item(sapf_pkg::REQ_EVALUATE, MIN_NEG, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, BW'(7), 1'b1);
    send_item(sapf_pkg::REQ_EVALUATE, '1, 1'b0);
    // Zero cooldown: diet times out at once.
    write_cooldown('0);
    send_item(sapf_pkg::REQ_EVALUATE, negated(3), 1'b0);
    // Short cooldown: overfed times out with a free, also a free of zero bytes.
    write_cooldown(COOLDOWN_W'(2));
    send_item(sapf_pkg::REQ_EVALUATE, negated(2), 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, negated(9), 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, negated(9), 1'b1);
    send_item(sapf_pkg::REQ_EVALUATE, MIN_NEG, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, '1, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, '0, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, '0, 1'b1);
    send_item(sapf_pkg::REQ_DIET, '0, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, MAX_POS, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, MAX_POS, 1'b0);

    // Failed allocations keep ticking the timer without a reload.
    write_cooldown('0);
    send_item(sapf_pkg::REQ_EVALUATE, '0, 1'b0);
    repeat (FAIL_ITEMS) begin
      send_item(sapf_pkg::REQ_EVALUATE,
                {1'b0, (BW-1)'({$urandom(), $urandom()})} | BW'(1), 1'b0);
    end
    send_item(sapf_pkg::REQ_EVALUATE, '1, 1'b0);
    send_item(sapf_pkg::REQ_EVALUATE, '1, 1'b0);

    // Random phases over a spread of cooldown settings and idle rates.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0:       ticks = '0;
        1:       ticks = COOLDOWN_W'(1);
        2:       ticks = COOLDOWN_W'(3);
        3:       ticks = COOLDOWN_W'($urandom_range(2, 12));
        4:       ticks = '1;
        5:       ticks = COOLDOWN_W'($urandom());
        default: ticks = sapf_pkg::COOLDOWN_RESET;
      endcase
      write_cooldown(ticks);
      tx_gap_pct   = (phase == 0) ? 0 : ((phase % 3 == 1) ? 50 : 15);
      rx_stall_pct = (phase == 0) ? 0 : ((phase % 3 == 2) ? 50 : 15);
      run_random(120);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
